FILE: rtl/pld_pkg.sv
package pld_pkg;

    // Field widths.
    localparam int POS_W   = 14;
    localparam int ERR_W   = 14;
    localparam int INTEG_W = 15;
    localparam int DERIV_W = 15;
    localparam int GAIN_W  = 18;
    localparam int SPEED_W = 8;
    localparam int MIN_W   = 9;
    localparam int PWM_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    // Datapath widths.
    localparam int ACC_W   = 35;
    localparam int FRAC_W  = 16;
    localparam int CORR_W  = ACC_W - FRAC_W;
    localparam int WHEEL_W = 21;

    // Control constants.
    localparam logic [POS_W-1:0]           POS_LIMIT   = 14'd12000;
    localparam logic signed [ERR_W:0]      CENTER_POS  = 15'sd6000;
    localparam logic signed [INTEG_W:0]    INTEG_LIMIT = 16'sd10000;
    localparam logic signed [INTEG_W:0]    INTEG_FLOOR = -16'sd10000;
    localparam logic [PWM_W-1:0]           PWM_LIMIT   = 8'd255;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CRUISE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd5;

    // Register reset values.
    localparam logic [SPEED_W-1:0]       CRUISE_RST   = 8'd120;
    localparam logic [SPEED_W-1:0]       SPEED_HI_RST = 8'd200;
    localparam logic signed [MIN_W-1:0]  SPEED_LO_RST = -9'sd180;
    localparam logic [GAIN_W-1:0]        GAIN_P_RST   = 18'd3801;
    localparam logic [GAIN_W-1:0]        GAIN_I_RST   = 18'd0;
    localparam logic [GAIN_W-1:0]        GAIN_D_RST   = 18'd16384;

    typedef struct packed {
        logic [SPEED_W-1:0]      cruise;
        logic [SPEED_W-1:0]      speed_hi;
        logic signed [MIN_W-1:0] speed_lo;
        logic [GAIN_W-1:0]       gain_p;
        logic [GAIN_W-1:0]       gain_i;
        logic [GAIN_W-1:0]       gain_d;
    } cfg_t;

    typedef struct packed {
        logic             forward;
        logic [PWM_W-1:0] pwm;
    } drive_t;

    // Clamp one wheel speed to the limits, then split it into direction and magnitude.
    function automatic drive_t wheel_drive(
        input logic signed [WHEEL_W-1:0] speed,
        input logic signed [MIN_W-1:0]   lo,
        input logic [SPEED_W-1:0]        hi
    );
        logic signed [WHEEL_W-1:0] lo_w;
        logic signed [WHEEL_W-1:0] hi_w;
        logic signed [WHEEL_W-1:0] v;
        logic [WHEEL_W-1:0]        mag;
        drive_t                    d;
        lo_w = WHEEL_W'(lo);
        hi_w = $signed({{(WHEEL_W-SPEED_W){1'b0}}, hi});
        if (speed < lo_w) begin
            v = lo_w;
        end else if (speed > hi_w) begin
            v = hi_w;
        end else begin
            v = speed;
        end
        d.forward = ~v[WHEEL_W-1];
        mag = v[WHEEL_W-1] ? WHEEL_W'(-v) : WHEEL_W'(v);
        if (mag > WHEEL_W'(PWM_LIMIT)) begin
            d.pwm = PWM_LIMIT;
        end else begin
            d.pwm = mag[PWM_W-1:0];
        end
        return d;
    endfunction

endpackage

FILE: rtl/pid_line_follow_drive.sv
// PID line-following drive controller for a differential-drive robot.
// Request channel: in_valid/in_ready carry one line_position (0..12000, 6000 is
// centered; larger values count as 12000). Result channel: out_valid/out_ready
// carry left/right direction bits and PWM magnitudes, one result per request.
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data writes
// cruise speed, upper speed limit, lower speed limit, gain_p, gain_i, gain_d
// (index 0..5); other indexes are dropped. cfg_ready is always high; write only
// while idle. A request passes through five registered stages before its result
// shows on out_valid: error and integral, three gain products, their sum,
// truncation to the correction, then wheel clamp and split. Throughput is one
// request per cycle while out_ready is high, and each stage advances whenever
// the stage after it is free.
// When out_ready is low the result is held and the stages fill up behind it;
// in_ready drops only when every stage holds a request.
// Reset empties the pipeline, clears the integral and previous error, and loads
// the default register values.
module pid_line_follow_drive
    import pld_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [POS_W-1:0]      line_position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  left_forward,
    output logic [PWM_W-1:0]      left_pwm,
    output logic                  right_forward,
    output logic [PWM_W-1:0]      right_pwm,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;

    logic signed [INTEG_W-1:0] integral_sum_reg;
    logic signed [ERR_W-1:0]   previous_error_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    logic signed [ERR_W-1:0]   err_reg;
    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [DERIV_W-1:0] deriv_reg;
    logic signed [ACC_W-1:0]   prod_p_reg, prod_i_reg, prod_d_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [CORR_W-1:0]  corr_reg;
    drive_t                    left_reg, right_reg;

    logic [POS_W-1:0]          pos_sat;
    logic signed [ERR_W:0]     err_w;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [INTEG_W:0]   integ_w;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [DERIV_W-1:0] deriv_next;
    logic signed [GAIN_W:0]    gp_s, gi_s, gd_s;
    logic signed [ERR_W+GAIN_W:0]     prod_p_w;
    logic signed [INTEG_W+GAIN_W:0]   prod_i_w;
    logic signed [DERIV_W+GAIN_W:0]   prod_d_w;
    logic signed [ACC_W-1:0]   acc_next;
    logic signed [ACC_W-1:0]   acc_biased;
    logic signed [CORR_W-1:0]  corr_next;
    logic signed [WHEEL_W-1:0] left_speed, right_speed;
    logic                      in_fire;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cruise   <= CRUISE_RST;
            cfg_reg.speed_hi <= SPEED_HI_RST;
            cfg_reg.speed_lo <= SPEED_LO_RST;
            cfg_reg.gain_p   <= GAIN_P_RST;
            cfg_reg.gain_i   <= GAIN_I_RST;
            cfg_reg.gain_d   <= GAIN_D_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CRUISE:   cfg_reg.cruise   <= cfg_data[SPEED_W-1:0];
                REG_SPEED_HI: cfg_reg.speed_hi <= cfg_data[SPEED_W-1:0];
                REG_SPEED_LO: cfg_reg.speed_lo <= $signed(cfg_data[MIN_W-1:0]);
                REG_GAIN_P:   cfg_reg.gain_p   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:   cfg_reg.gain_i   <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:   cfg_reg.gain_d   <= cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Each stage may load when it is empty or the stage after it moves on.
    assign rdy5     = !v5_reg || out_ready;
    assign rdy4     = !v4_reg || rdy5;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign in_fire  = in_valid && in_ready;

    // Error, saturated integral and derivative from the incoming position.
    always_comb
    begin
        pos_sat  = (line_position > POS_LIMIT) ? POS_LIMIT : line_position;
        err_w    = CENTER_POS - $signed({1'b0, pos_sat});
        err_next = err_w[ERR_W-1:0];
        integ_w  = (INTEG_W+1)'(integral_sum_reg) + (INTEG_W+1)'(err_next);
        if (integ_w > INTEG_LIMIT)
        begin
            integ_next = INTEG_LIMIT[INTEG_W-1:0];
        end
        else if (integ_w < INTEG_FLOOR)
        begin
            integ_next = INTEG_FLOOR[INTEG_W-1:0];
        end
        else
        begin
            integ_next = integ_w[INTEG_W-1:0];
        end
        deriv_next = DERIV_W'(err_next) - DERIV_W'(previous_error_reg);
    end

    // Controller state advances with every accepted request.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_sum_reg   <= '0;
            previous_error_reg <= '0;
        end
        else if (in_fire)
        begin
            integral_sum_reg   <= integ_next;
            previous_error_reg <= err_next;
        end
    end

    // Gain products, sum, truncation toward zero and wheel outputs.
    always_comb
    begin
        gp_s       = $signed({1'b0, cfg_reg.gain_p});
        gi_s       = $signed({1'b0, cfg_reg.gain_i});
        gd_s       = $signed({1'b0, cfg_reg.gain_d});
        prod_p_w   = err_reg * gp_s;
        prod_i_w   = integ_reg * gi_s;
        prod_d_w   = deriv_reg * gd_s;
        acc_next   = prod_p_reg + prod_i_reg + prod_d_reg;
        acc_biased = acc_reg + (acc_reg[ACC_W-1] ? ACC_W'({FRAC_W{1'b1}}) : '0);
        corr_next  = acc_biased[ACC_W-1:FRAC_W];
        left_speed  = $signed({{(WHEEL_W-SPEED_W){1'b0}}, cfg_reg.cruise})
                    + WHEEL_W'(corr_reg);
        right_speed = $signed({{(WHEEL_W-SPEED_W){1'b0}}, cfg_reg.cruise})
                    - WHEEL_W'(corr_reg);
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= in_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            err_reg   <= err_next;
            integ_reg <= integ_next;
            deriv_reg <= deriv_next;
        end
        if (rdy2 && v1_reg)
        begin
            prod_p_reg <= ACC_W'(prod_p_w);
            prod_i_reg <= ACC_W'(prod_i_w);
            prod_d_reg <= ACC_W'(prod_d_w);
        end
        if (rdy3 && v2_reg)
        begin
            acc_reg <= acc_next;
        end
        if (rdy4 && v3_reg)
        begin
            corr_reg <= corr_next;
        end
        if (rdy5 && v4_reg)
        begin
            left_reg  <= wheel_drive(left_speed, cfg_reg.speed_lo, cfg_reg.speed_hi);
            right_reg <= wheel_drive(right_speed, cfg_reg.speed_lo, cfg_reg.speed_hi);
        end
    end

    assign out_valid     = v5_reg;
    assign left_forward  = left_reg.forward;
    assign left_pwm      = left_reg.pwm;
    assign right_forward = right_reg.forward;
    assign right_pwm     = right_reg.pwm;

    // The integral never leaves its saturation band.
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integral_sum_reg <= 15'sd10000) && (integral_sum_reg >= -15'sd10000))
        else $error("integral outside saturation band");

    // The stored error stays within the centered position range.
    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (previous_error_reg <= 14'sd6000) && (previous_error_reg >= -14'sd6000))
        else $error("previous error outside position range");

    // An accepted request always occupies the first stage next cycle.
    a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> v1_reg)
        else $error("accepted request lost at first stage");

    // A reversing left wheel always has a nonzero magnitude.
    a_reverse_mag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !left_forward) |-> (left_pwm != '0))
        else $error("left reverse with zero magnitude");

    // A stalled result keeps the whole pipeline from accepting when full.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg && !out_ready) |-> !in_ready)
        else $error("request accepted into a full stalled pipeline");

endmodule
